/* hdl/rdq_pkg.sv */
package rdq_pkg;

  // Ring store depth and derived widths
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

  // Word read back when the queue is empty
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [COUNT_W-1:0]       count;
    logic [STAT_W-1:0]        status;
  } out_word_t;

endpackage

/* hdl/reversible_deque.sv */
// Double-ended queue of signed 32-bit words with a constant-time reverse.
//
// Input channel (in_valid / in_stall / in_data): each word carries a command
// (push back, push front, pop back, pop front, reverse, peek; codes 6 and 7
// act as peek) and a value used by pushes. A word is taken at a rising edge
// with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_data): exactly one result word
// per command, giving the logical front and back words (-1 when empty), the
// count held and a status (ok, pop on empty ignored, push on full ignored).
//
// Sequence: the accepting edge updates pointers and writes the ring store,
// the store is then read at both physical ends into registered read ports,
// and the output register loads from them once the output is free.
// One command is in flight at a time: the input stalls from acceptance until
// its result has loaded into the output register.
// Reset (rst_n low, synchronous) empties the queue, clears the reverse flag
// and drops any pending result; the store contents are left as they are.
// While out_stall is high the result holds; the next command is still taken,
// and the input then stalls until its result can load.
module reversible_deque (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rdq_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rdq_pkg::out_word_t out_data
);
  import rdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    ring_prev = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // Ring store and its registered read ports
  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_first_r;
  logic [WORD_W-1:0] rd_last_r;

  // Control state
  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  first_r, first_nxt;
  logic [PTR_W-1:0]  last_r, last_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              rev_r, rev_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  // Output register
  logic              out_valid_r;
  out_word_t         out_data_r, out_data_nxt;

  logic              in_acc;
  logic              out_free;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              at_last;
  logic              empty;
  logic              full;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign empty = (occ_r == '0);
  assign full  = (occ_r == OCC_FULL);

  // Work out the command's effect on pointers, count and flag
  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    occ_nxt   = occ_r;
    rev_nxt   = rev_r;
    stat_nxt  = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = first_r;
    // physical end selected by the command under the reverse flag
    at_last   = (in_data.cmd == CMD_PUSH_BACK || in_data.cmd == CMD_POP_BACK) ? !rev_r
                                                                               : rev_r;
    case (in_data.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          stat_nxt = ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          occ_nxt = occ_r + 1'b1;
          if (empty) begin
            // first word lands at first_r and both ends meet there
            last_nxt = first_r;
            wr_addr  = first_r;
          end else if (at_last) begin
            last_nxt = ring_next(last_r);
            wr_addr  = ring_next(last_r);
          end else begin
            first_nxt = ring_prev(first_r);
            wr_addr   = ring_prev(first_r);
          end
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (empty) begin
          stat_nxt = ST_POP_EMPTY;
        end else begin
          occ_nxt = occ_r - 1'b1;
          if (occ_r == OCC_W'(1)) begin
            last_nxt = first_r;
          end else if (at_last) begin
            last_nxt = ring_prev(last_r);
          end else begin
            first_nxt = ring_next(first_r);
          end
        end
      end
      CMD_REVERSE: begin
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase
  end

  // Sequence: update, read both ends, load result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_READ;
      S_READ:  state_nxt = S_LOAD;
      S_LOAD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Assemble the result from the read ports
  always_comb begin
    out_data_nxt.count  = COUNT_W'(occ_r);
    out_data_nxt.status = stat_r;
    if (occ_r == '0) begin
      out_data_nxt.front_value = EMPTY_WORD;
      out_data_nxt.back_value  = EMPTY_WORD;
    end else if (rev_r) begin
      out_data_nxt.front_value = rd_last_r;
      out_data_nxt.back_value  = rd_first_r;
    end else begin
      out_data_nxt.front_value = rd_first_r;
      out_data_nxt.back_value  = rd_last_r;
    end
  end

  // Ring store: write on accept, read both ends in the following cycle
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem_r[wr_addr] <= in_data.value;
    end
    if (state_r == S_READ) begin
      rd_first_r <= mem_r[first_r];
      rd_last_r  <= mem_r[last_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      last_r      <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        first_r <= first_nxt;
        last_r  <= last_nxt;
        occ_r   <= occ_nxt;
        rev_r   <= rev_nxt;
        stat_r  <= stat_nxt;
      end
      // hold the result while stalled, advance when a new one loads
      if (state_r == S_LOAD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* hdl/rdq_checker.sv */
module rdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rdq_pkg::out_word_t out_data
);
  import rdq_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  // an empty queue reads -1 at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.count == '0 |->
      out_data.front_value == EMPTY_WORD && out_data.back_value == EMPTY_WORD)
    else $error("empty queue does not read -1 at both ends");

  // one command in flight: input stalls after each accepted word
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in flight");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (.*);
